[src/union_find_component_stats_defines.svh]
// assertion macros shared by the checker of union_find_component_stats
// depends on nothing; expects clk and arst_n in scope where used
`ifndef UNION_FIND_COMPONENT_STATS_DEFINES_SVH
`define UNION_FIND_COMPONENT_STATS_DEFINES_SVH

// same-cycle implication, quiet during reset
`define UFCS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet during reset
`define UFCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/ufcs_pkg.sv]
// shared types and constants for the union-find component statistics block
// depends on nothing
package ufcs_pkg;

	localparam int unsigned IDX_W = 10;
	localparam int unsigned CNT_W = 11;
	localparam int unsigned STAT_W = 32;

	typedef enum logic {
		ACT_EDGE = 1'b0,
		ACT_QUERY = 1'b1
	} action_t;

	typedef struct packed {
		action_t action;
		logic [IDX_W-1:0] a;
		logic [IDX_W-1:0] b;
		logic err;
	} item_t;

	// queue head seen by the back end
	typedef struct packed {
		logic valid;
		item_t item;
	} qhead_t;

	// back end to front end
	typedef struct packed {
		logic pop;
		logic clearing;
	} bctl_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_BUMP_RD,
		ST_BUMP_WR,
		ST_FIND_RD,
		ST_FIND_CHK,
		ST_UPD,
		ST_MERGE,
		ST_LINK,
		ST_EMIT
	} bstate_t;

	typedef enum logic [1:0] {
		PH_A,
		PH_B,
		PH_Q
	} phase_t;

	function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] x);
		return (x == '1) ? x : x + STAT_W'(1);
	endfunction

	function automatic logic [STAT_W-1:0] sat_add(input logic [STAT_W-1:0] x,
			input logic [STAT_W-1:0] y);
		logic [STAT_W:0] s;
		s = {1'b0, x} + {1'b0, y};
		return s[STAT_W] ? '1 : s[STAT_W-1:0];
	endfunction

endpackage

[src/ufcs_front.sv]
// front end: node count register, index check and a two-word queue
// depends on ufcs_pkg
module ufcs_front #(
	parameter int unsigned NODES = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [ufcs_pkg::CNT_W-1:0] cfg_wdata,
	input  logic in_valid,
	output logic in_stall,
	input  ufcs_pkg::action_t action,
	input  logic [ufcs_pkg::IDX_W-1:0] node_a,
	input  logic [ufcs_pkg::IDX_W-1:0] node_b,
	output ufcs_pkg::qhead_t qhead,
	input  ufcs_pkg::bctl_t bctl
);
	import ufcs_pkg::*;

	logic [CNT_W-1:0] node_count_q;
	item_t slot_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	logic a_ok, b_ok, push, pop;
	item_t cls;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CNT_W'(1024);
		end else if (cfg_we) begin
			node_count_q <= cfg_wdata;
		end
	end

	// index is valid below both the node count and the store depth
	always_comb begin
		a_ok = (32'(node_a) < 32'(node_count_q)) && (32'(node_a) < NODES);
		b_ok = (32'(node_b) < 32'(node_count_q)) && (32'(node_b) < NODES);
		cls.action = action;
		cls.a = node_a;
		cls.b = node_b;
		cls.err = !a_ok || (action == ACT_EDGE && !b_ok);
	end

	assign in_stall = (cnt_q == 2'd2) || bctl.clearing;
	assign push = in_valid && !in_stall;
	assign pop = bctl.pop && (cnt_q != 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign qhead.valid = (cnt_q != 2'd0);
	assign qhead.item = slot_q[rd_q];

endmodule

[src/ufcs_back.sv]
// back end: node memory, clearing pass, find walks, merges and result register
// depends on ufcs_pkg
module ufcs_back #(
	parameter int unsigned NODES = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  ufcs_pkg::qhead_t qhead,
	output ufcs_pkg::bctl_t bctl,
	output logic out_valid,
	input  logic out_stall,
	output logic [ufcs_pkg::IDX_W-1:0] root,
	output logic [ufcs_pkg::CNT_W-1:0] comp_size,
	output logic [ufcs_pkg::STAT_W-1:0] degree_sum,
	output logic [ufcs_pkg::STAT_W-1:0] max_degree,
	output logic joined,
	output logic error
);
	import ufcs_pkg::*;

	localparam int unsigned IW = $clog2(NODES);

	typedef struct packed {
		logic [IW-1:0] par;
		logic [CNT_W-1:0] size;
		logic [STAT_W-1:0] deg;
		logic [STAT_W-1:0] dsum;
		logic [STAT_W-1:0] maxd;
	} ent_t;

	ent_t mem [NODES];
	ent_t rdata_q;

	bstate_t st_q, st_d;
	phase_t ph_q;
	logic [IW-1:0] cur_q, ra_q, clr_q, b_q;
	logic [STAT_W-1:0] dnew_q;
	ent_t root_q, rb_ent_q;

	logic [IDX_W-1:0] res_root_q;
	logic [CNT_W-1:0] res_size_q;
	logic [STAT_W-1:0] res_dsum_q, res_maxd_q;
	logic res_join_q, res_err_q;

	logic out_free;
	logic mem_we, mem_re;
	logic [IW-1:0] waddr, raddr;
	ent_t wdata, upd_ent, mrg_ent;

	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		if (mem_re) rdata_q <= mem[raddr];
	end

	// root entry after a degree bump, and root entry after a merge
	always_comb begin
		upd_ent = root_q;
		upd_ent.dsum = sat_inc(root_q.dsum);
		if (dnew_q > root_q.maxd) upd_ent.maxd = dnew_q;
		mrg_ent = rdata_q;
		mrg_ent.size = rdata_q.size + rb_ent_q.size;
		mrg_ent.dsum = sat_add(rdata_q.dsum, rb_ent_q.dsum);
		if (rb_ent_q.maxd > rdata_q.maxd) mrg_ent.maxd = rb_ent_q.maxd;
	end

	always_comb begin
		st_d = st_q;
		mem_we = 1'b0;
		mem_re = 1'b0;
		waddr = cur_q;
		raddr = cur_q;
		wdata = rdata_q;
		bctl.pop = 1'b0;
		bctl.clearing = (st_q == ST_CLR);
		case (st_q)
			ST_CLR: begin
				mem_we = 1'b1;
				waddr = clr_q;
				wdata = '0;
				wdata.par = clr_q;
				wdata.size = CNT_W'(1);
				if (clr_q == IW'(NODES - 1)) st_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (qhead.valid) begin
					bctl.pop = 1'b1;
					if (qhead.item.err) st_d = ST_EMIT;
					else if (qhead.item.action == ACT_QUERY) st_d = ST_FIND_RD;
					else st_d = ST_BUMP_RD;
				end
			end
			ST_BUMP_RD: begin
				mem_re = 1'b1;
				st_d = ST_BUMP_WR;
			end
			ST_BUMP_WR: begin
				mem_we = 1'b1;
				wdata.deg = sat_inc(rdata_q.deg);
				st_d = ST_FIND_RD;
			end
			ST_FIND_RD: begin
				mem_re = 1'b1;
				st_d = ST_FIND_CHK;
			end
			ST_FIND_CHK: begin
				if (rdata_q.par != cur_q) st_d = ST_FIND_RD;
				else if (ph_q == PH_Q) st_d = ST_EMIT;
				else st_d = ST_UPD;
			end
			ST_UPD: begin
				mem_we = 1'b1;
				wdata = upd_ent;
				if (ph_q == PH_A) begin
					st_d = ST_BUMP_RD;
				end else begin
					// second root: fetch the first root, and merge when they differ
					mem_re = 1'b1;
					raddr = ra_q;
					st_d = (ra_q != cur_q) ? ST_MERGE : ST_EMIT;
				end
			end
			ST_MERGE: begin
				mem_we = 1'b1;
				waddr = ra_q;
				wdata = mrg_ent;
				st_d = ST_LINK;
			end
			ST_LINK: begin
				mem_we = 1'b1;
				waddr = cur_q;
				wdata = rb_ent_q;
				wdata.par = ra_q;
				st_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR;
			clr_q <= '0;
			ph_q <= PH_A;
		end else begin
			st_q <= st_d;
			if (st_q == ST_CLR) clr_q <= clr_q + IW'(1);
			if (st_q == ST_IDLE && qhead.valid)
				ph_q <= (qhead.item.action == ACT_QUERY) ? PH_Q : PH_A;
			if (st_q == ST_UPD && ph_q == PH_A) ph_q <= PH_B;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				cur_q <= IW'(qhead.item.a);
				b_q <= IW'(qhead.item.b);
				res_root_q <= '0;
				res_size_q <= '0;
				res_dsum_q <= '0;
				res_maxd_q <= '0;
				res_join_q <= 1'b0;
				res_err_q <= qhead.item.err;
			end
			ST_BUMP_WR: dnew_q <= sat_inc(rdata_q.deg);
			ST_FIND_CHK: begin
				if (rdata_q.par != cur_q) begin
					cur_q <= rdata_q.par;
				end else begin
					root_q <= rdata_q;
					res_root_q <= IDX_W'(cur_q);
					res_size_q <= rdata_q.size;
					res_dsum_q <= rdata_q.dsum;
					res_maxd_q <= rdata_q.maxd;
				end
			end
			ST_UPD: begin
				if (ph_q == PH_A) begin
					ra_q <= cur_q;
					cur_q <= b_q;
				end else begin
					rb_ent_q <= upd_ent;
					res_root_q <= IDX_W'(cur_q);
					res_size_q <= upd_ent.size;
					res_dsum_q <= upd_ent.dsum;
					res_maxd_q <= upd_ent.maxd;
				end
			end
			ST_MERGE: begin
				res_root_q <= IDX_W'(ra_q);
				res_size_q <= mrg_ent.size;
				res_dsum_q <= mrg_ent.dsum;
				res_maxd_q <= mrg_ent.maxd;
				res_join_q <= 1'b1;
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (st_q == ST_EMIT && out_free) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_EMIT && out_free) begin
			root <= res_root_q;
			comp_size <= res_size_q;
			degree_sum <= res_dsum_q;
			max_degree <= res_maxd_q;
			joined <= res_join_q;
			error <= res_err_q;
		end
	end

endmodule

[src/union_find_component_stats.sv]
// top level of the union-find component statistics block
// depends on ufcs_pkg, ufcs_front and ufcs_back
//
// disjoint-set engine over NODES nodes with per-component statistics. each
// input word is an edge (action 0) or a query of node_a (action 1); each one
// gives exactly one result word: the root of node_a's component, its node
// count, degree sum and largest degree (both saturating at all ones), a
// joined flag for an edge that merged two components, and an error flag for
// a node index not below node_count or NODES (then nothing changes and all
// other fields are zero). after reset a clearing pass over all NODES entries
// initializes the node memory; input stays stalled during it, node_count
// writes are taken at any time. all node records live in one memory with one
// read and one write port, and the back end walks parent pointers through it
// one step at a time, a read and then a check per step, so the walk depth
// sets the rate. a two-word queue in front lets new words be accepted while
// the back end works, and the result register lets the back end go on while
// a result waits to be taken
module union_find_component_stats #(
	parameter int unsigned NODES = 1024
) (
	input  logic clk,
	input  logic arst_n,
	// node_count register
	input  logic cfg_we,
	input  logic [ufcs_pkg::CNT_W-1:0] cfg_wdata,
	// input word
	input  logic in_valid,
	output logic in_stall,
	input  logic [0:0] action,
	input  logic [ufcs_pkg::IDX_W-1:0] node_a,
	input  logic [ufcs_pkg::IDX_W-1:0] node_b,
	// result word
	output logic out_valid,
	input  logic out_stall,
	output logic [ufcs_pkg::IDX_W-1:0] root,
	output logic [ufcs_pkg::CNT_W-1:0] comp_size,
	output logic [ufcs_pkg::STAT_W-1:0] degree_sum,
	output logic [ufcs_pkg::STAT_W-1:0] max_degree,
	output logic joined,
	output logic error
);
	import ufcs_pkg::*;

	qhead_t qhead;
	bctl_t bctl;

	// accept, index check, queue
	ufcs_front #(.NODES(NODES)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action_t'(action)),
		.node_a(node_a),
		.node_b(node_b),
		.qhead(qhead),
		.bctl(bctl)
	);

	// finds, degree updates, merges, result register
	ufcs_back #(.NODES(NODES)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.qhead(qhead),
		.bctl(bctl),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.root(root),
		.comp_size(comp_size),
		.degree_sum(degree_sum),
		.max_degree(max_degree),
		.joined(joined),
		.error(error)
	);

endmodule

[src/ufcs_checker.sv]
// port-level checks for union_find_component_stats, bound to the top level
// depends on ufcs_pkg and union_find_component_stats_defines.svh
`include "union_find_component_stats_defines.svh"

module ufcs_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic [ufcs_pkg::IDX_W-1:0] root,
	input logic [ufcs_pkg::STAT_W-1:0] degree_sum,
	input logic [ufcs_pkg::STAT_W-1:0] max_degree,
	input logic [ufcs_pkg::CNT_W-1:0] comp_size,
	input logic joined,
	input logic error
);
	import ufcs_pkg::*;

	`UFCS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(root) && $stable(degree_sum), "stalled result word changed")
	`UFCS_ASSERT_NOW(a_err_zero, out_valid && error, root == '0 && comp_size == '0 && degree_sum == '0 && max_degree == '0 && !joined, "error word carries data")
	`UFCS_ASSERT_NOW(a_max_le_sum, out_valid && !error, max_degree <= degree_sum, "largest degree above degree sum")
	`UFCS_ASSERT_NOW(a_join_deg, out_valid && joined, !error && degree_sum >= STAT_W'(2), "merge with too small degree sum")

endmodule

bind union_find_component_stats ufcs_checker u_ufcs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.root(root),
	.degree_sum(degree_sum),
	.max_degree(max_degree),
	.comp_size(comp_size),
	.joined(joined),
	.error(error)
);
